// ===== src/abpf_pkg.sv =====
package abpf_pkg;

    localparam logic [2:0] FMT_RGB24  = 3'd0;
    localparam logic [2:0] FMT_BGR24  = 3'd1;
    localparam logic [2:0] FMT_RGBX32 = 3'd2;
    localparam logic [2:0] FMT_BGRX32 = 3'd3;
    localparam logic [2:0] FMT_RGBA32 = 3'd4;
    localparam logic [2:0] FMT_GREYA  = 3'd5;

    localparam logic [7:0] FULL = 8'hFF;

    // Reciprocals for exact truncating division: floor(x/d) = (x*M) >> s
    localparam int         DIV255_SHIFT   = 24;
    localparam logic [16:0] DIV255_MUL    = 17'(((64'd1 << 24) + 64'd254) / 64'd255);
    localparam int         DIV65025_SHIFT = 40;
    localparam logic [24:0] DIV65025_MUL  =
        25'(((64'd1 << 40) + 64'd65024) / 64'd65025);
    localparam int         DIV3_SHIFT     = 12;
    localparam logic [10:0] DIV3_MUL      = 11'(((64'd1 << 12) + 64'd2) / 64'd3);

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_byte0;
        logic [7:0] dst_byte1;
        logic [7:0] dst_byte2;
        logic [7:0] dst_byte3;
    } in_item_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
    } out_item_t;

    // Fields carried unchanged down the pipeline
    typedef struct packed {
        logic [2:0][7:0] sc;     // 0 red, 1 green, 2 blue
        logic [7:0]      sa;
        logic [3:0][7:0] dst;
        logic [2:0]      fmt;
        logic            pass;   // transparent source or bad format
        logic            copy;   // opaque source
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [2:0][7:0] dc;
        logic [7:0]      da;
    } dec_item_t;

    typedef struct packed {
        side_t           side;
        logic [2:0][7:0] q;      // sc*sa/255
        logic [2:0][7:0] z;      // dc*da*(255-sa)/65025
        logic [7:0]      tq;     // da*(255-sa)/255
    } mix_item_t;

endpackage

// ===== src/abpf_decode.sv =====
module abpf_decode
    import abpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [2:0] fmt,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output dec_item_t out_data
);

    logic      v_reg;
    dec_item_t d_reg;
    dec_item_t d_next;
    logic      rdy;

    assign rdy      = !v_reg || !out_stall;
    assign in_stall = !rdy;

    always_comb
    begin
        d_next.side.sc[0] = in_data.src_red;
        d_next.side.sc[1] = in_data.src_green;
        d_next.side.sc[2] = in_data.src_blue;
        d_next.side.sa    = in_data.src_alpha;
        d_next.side.dst[0] = in_data.dst_byte0;
        d_next.side.dst[1] = in_data.dst_byte1;
        d_next.side.dst[2] = in_data.dst_byte2;
        d_next.side.dst[3] = in_data.dst_byte3;
        d_next.side.fmt   = fmt;
        d_next.side.pass  = (in_data.src_alpha == 8'd0) || (fmt > FMT_GREYA);
        d_next.side.copy  = (in_data.src_alpha == FULL);
        d_next.dc[0] = in_data.dst_byte0;
        d_next.dc[1] = in_data.dst_byte1;
        d_next.dc[2] = in_data.dst_byte2;
        d_next.da    = FULL;
        case (fmt) inside
            FMT_BGR24, FMT_BGRX32:
            begin
                d_next.dc[0] = in_data.dst_byte2;
                d_next.dc[2] = in_data.dst_byte0;
            end
            FMT_GREYA:
            begin
                d_next.dc[1] = in_data.dst_byte0;
                d_next.dc[2] = in_data.dst_byte0;
                d_next.da    = in_data.dst_byte1;
            end
            FMT_RGBA32:
            begin
                d_next.da = in_data.dst_byte3;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// ===== src/abpf_mix.sv =====
module abpf_mix
    import abpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dec_item_t in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output mix_item_t out_data
);

    // stage A: products; stage B: second product and /255; stage C: /65025
    logic             va_reg, vb_reg, vc_reg;
    logic             rdy_a, rdy_b, rdy_c;

    side_t            a_side_reg;
    logic [2:0][15:0] a_sp_reg;
    logic [2:0][7:0]  a_dc_reg;
    logic [15:0]      a_t_reg;
    logic [2:0][15:0] a_sp_next;
    logic [15:0]      a_t_next;

    side_t            b_side_reg;
    logic [2:0][7:0]  b_q_reg;
    logic [2:0][23:0] b_y_reg;
    logic [7:0]       b_tq_reg;
    logic [2:0][7:0]  b_q_next;
    logic [2:0][23:0] b_y_next;
    logic [7:0]       b_tq_next;
    logic [2:0][32:0] b_qp;
    logic [32:0]      b_tp;

    mix_item_t        c_reg;
    mix_item_t        c_next;
    logic [2:0][48:0] c_zp;

    assign rdy_c    = !vc_reg || !out_stall;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_stall = !rdy_a;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_sp_next[i] = 16'(in_data.side.sc[i]) * 16'(in_data.side.sa);
        a_t_next = 16'(in_data.da) * 16'(FULL - in_data.side.sa);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_qp[i]     = 33'(a_sp_reg[i]) * 33'(DIV255_MUL);
            b_q_next[i] = b_qp[i][DIV255_SHIFT +: 8];
            b_y_next[i] = 24'(a_dc_reg[i]) * 24'(a_t_reg);
        end
        b_tp      = 33'(a_t_reg) * 33'(DIV255_MUL);
        b_tq_next = b_tp[DIV255_SHIFT +: 8];
    end

    always_comb
    begin
        c_next.side = b_side_reg;
        c_next.q    = b_q_reg;
        c_next.tq   = b_tq_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_zp[i]     = 49'(b_y_reg[i]) * 49'(DIV65025_MUL);
            c_next.z[i] = c_zp[i][DIV65025_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
            if (rdy_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_side_reg <= in_data.side;
            a_sp_reg   <= a_sp_next;
            a_dc_reg   <= in_data.dc;
            a_t_reg    <= a_t_next;
        end
        if (rdy_b)
        begin
            b_side_reg <= a_side_reg;
            b_q_reg    <= b_q_next;
            b_y_reg    <= b_y_next;
            b_tq_reg   <= b_tq_next;
        end
        if (rdy_c)
            c_reg <= c_next;
    end

    assign out_valid = vc_reg;
    assign out_data  = c_reg;

endmodule

// ===== src/abpf_encode.sv =====
module abpf_encode
    import abpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  mix_item_t in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // stage A: channel sums and opaque select; stage B: gray and byte packing
    logic            va_reg, vb_reg;
    logic            rdy_a, rdy_b;

    side_t           a_side_reg;
    logic [2:0][7:0] a_c_reg;
    logic [7:0]      a_alpha_reg;
    logic [9:0]      a_sum_reg;
    logic [2:0][7:0] a_c_next;
    logic [7:0]      a_alpha_next;

    out_item_t       b_reg;
    out_item_t       b_next;
    logic [20:0]     grey_p;
    logic [7:0]      grey;

    assign rdy_b    = !vb_reg || !out_stall;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_stall = !rdy_a;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_c_next[i] = in_data.side.copy ? in_data.side.sc[i]
                                            : in_data.q[i] + in_data.z[i];
        a_alpha_next = in_data.side.copy ? in_data.side.sa
                                         : in_data.side.sa + in_data.tq;
    end

    always_comb
    begin
        grey_p = 21'(a_sum_reg) * 21'(DIV3_MUL);
        grey   = grey_p[DIV3_SHIFT +: 8];

        b_next.write_enable = !a_side_reg.pass;
        b_next.out_byte0    = a_side_reg.dst[0];
        b_next.out_byte1    = a_side_reg.dst[1];
        b_next.out_byte2    = a_side_reg.dst[2];
        b_next.out_byte3    = a_side_reg.dst[3];
        if (!a_side_reg.pass)
        begin
            case (a_side_reg.fmt) inside
                FMT_BGR24, FMT_BGRX32:
                begin
                    b_next.out_byte0 = a_c_reg[2];
                    b_next.out_byte1 = a_c_reg[1];
                    b_next.out_byte2 = a_c_reg[0];
                end
                FMT_GREYA:
                begin
                    b_next.out_byte0 = grey;
                    b_next.out_byte1 = a_alpha_reg;
                end
                default:
                begin
                    b_next.out_byte0 = a_c_reg[0];
                    b_next.out_byte1 = a_c_reg[1];
                    b_next.out_byte2 = a_c_reg[2];
                end
            endcase
            case (a_side_reg.fmt) inside
                FMT_RGBX32, FMT_BGRX32: b_next.out_byte3 = FULL;
                FMT_RGBA32:             b_next.out_byte3 = a_alpha_reg;
                default:                b_next.out_byte3 = a_side_reg.dst[3];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            a_side_reg  <= in_data.side;
            a_c_reg     <= a_c_next;
            a_alpha_reg <= a_alpha_next;
            a_sum_reg   <= 10'(a_c_next[0]) + 10'(a_c_next[1]) + 10'(a_c_next[2]);
        end
        if (rdy_b)
            b_reg <= b_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

// ===== src/alpha_blend_pixel_format_top.sv =====
// Throughput: one item per cycle when the output is not stalled; six register stages
// (decode, three multiply/divide stages, blend/sum, gray divide and pack), each
// holding its item when stalled; a result is valid once it has passed all six.
// Reset: rst_n asynchronous, active low; clears all stage valid bits and sets
// pixel_format to RGBA32.
module alpha_blend_pixel_format_top
    import abpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [2:0] pixel_format_reg;

    logic       dec_valid, dec_stall;
    dec_item_t  dec_data;
    logic       mix_valid, mix_stall;
    mix_item_t  mix_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_format_reg <= FMT_RGBA32;
        else if (cfg_we)
            pixel_format_reg <= cfg_wdata;
    end

    abpf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (pixel_format_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (dec_valid),
        .out_stall (dec_stall),
        .out_data  (dec_data)
    );

    abpf_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_stall  (dec_stall),
        .in_data   (dec_data),
        .out_valid (mix_valid),
        .out_stall (mix_stall),
        .out_data  (mix_data)
    );

    abpf_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_stall  (mix_stall),
        .in_data   (mix_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== src/abpf_checker.sv =====
module abpf_checker
    import abpf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // held result must not change or drop
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an empty output stage never backs up the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // transparent item flows through six stages unwritten, destination bytes 0 and 3 unchanged
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.src_alpha == 8'd0 && !out_stall)
        ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid && !out_data.write_enable
            && out_data.out_byte0 == $past(in_data.dst_byte0, 6)
            && out_data.out_byte3 == $past(in_data.dst_byte3, 6))
        else $error("transparent item not passed through");

endmodule

bind alpha_blend_pixel_format_top abpf_checker u_abpf_checker (.*);

// ===== bench/abpf_blend_check.sv =====
module abpf_blend_check
    import abpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_data,
    output int         wrong_pixels,
    output int         pixels_waiting,
    output int         pixels_compared
);

    localparam int unsigned OPAQUE    = 255;
    localparam int unsigned OPAQUE_SQ = OPAQUE * OPAQUE;

    logic [2:0] fmt_shadow;
    out_item_t  blended_q[$];

    function automatic int unsigned over_channel(int unsigned sc, int unsigned sa,
                                                 int unsigned dc, int unsigned da);
        return (sc * sa) / OPAQUE + (dc * da * (OPAQUE - sa)) / OPAQUE_SQ;
    endfunction

    function automatic out_item_t blend_pixel(in_item_t px, logic [2:0] fmt);
        int unsigned sa, dr, dg, db, da, r, g, b, a;
        out_item_t   res;
        res.write_enable = 1'b0;
        res.out_byte0    = px.dst_byte0;
        res.out_byte1    = px.dst_byte1;
        res.out_byte2    = px.dst_byte2;
        res.out_byte3    = px.dst_byte3;
        sa = 32'(px.src_alpha);
        // transparent source or undefined format: destination untouched
        if (sa == 0 || fmt > FMT_GREYA)
            return res;
        da = OPAQUE;
        case (fmt) inside
            FMT_BGR24, FMT_BGRX32:
            begin
                dr = 32'(px.dst_byte2);
                dg = 32'(px.dst_byte1);
                db = 32'(px.dst_byte0);
            end
            FMT_GREYA:
            begin
                dr = 32'(px.dst_byte0);
                dg = 32'(px.dst_byte0);
                db = 32'(px.dst_byte0);
                da = 32'(px.dst_byte1);
            end
            default:
            begin
                dr = 32'(px.dst_byte0);
                dg = 32'(px.dst_byte1);
                db = 32'(px.dst_byte2);
                if (fmt == FMT_RGBA32)
                    da = 32'(px.dst_byte3);
            end
        endcase
        if (sa == OPAQUE)
        begin
            r = 32'(px.src_red);
            g = 32'(px.src_green);
            b = 32'(px.src_blue);
            a = sa;
        end
        else
        begin
            r = over_channel(32'(px.src_red), sa, dr, da) & OPAQUE;
            g = over_channel(32'(px.src_green), sa, dg, da) & OPAQUE;
            b = over_channel(32'(px.src_blue), sa, db, da) & OPAQUE;
            a = (sa + (da * (OPAQUE - sa)) / OPAQUE) & OPAQUE;
        end
        case (fmt) inside
            FMT_BGR24, FMT_BGRX32:
            begin
                res.out_byte0 = 8'(b);
                res.out_byte1 = 8'(g);
                res.out_byte2 = 8'(r);
            end
            FMT_GREYA:
            begin
                res.out_byte0 = 8'((r + g + b) / 3);
                res.out_byte1 = 8'(a);
            end
            default:
            begin
                res.out_byte0 = 8'(r);
                res.out_byte1 = 8'(g);
                res.out_byte2 = 8'(b);
            end
        endcase
        if (fmt == FMT_RGBX32 || fmt == FMT_BGRX32)
            res.out_byte3 = FULL;
        else if (fmt == FMT_RGBA32)
            res.out_byte3 = 8'(a);
        res.write_enable = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            fmt_shadow      <= FMT_RGBA32;
            wrong_pixels    <= 0;
            pixels_waiting  <= 0;
            pixels_compared <= 0;
        end
        else
        begin
            if (cfg_we)
                fmt_shadow <= cfg_wdata;
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (blended_q.size() == 0)
                begin
                    if (wrong_pixels < 10)
                        $display("unexpected pixel: we=%b bytes %h %h %h %h",
                                 got.write_enable, got.out_byte0, got.out_byte1,
                                 got.out_byte2, got.out_byte3);
                    wrong_pixels <= wrong_pixels + 1;
                end
                else
                begin
                    want = blended_q.pop_front();
                    pixels_compared <= pixels_compared + 1;
                    if (got.write_enable !== want.write_enable ||
                        got.out_byte0 !== want.out_byte0 ||
                        got.out_byte1 !== want.out_byte1 ||
                        got.out_byte2 !== want.out_byte2 ||
                        got.out_byte3 !== want.out_byte3)
                    begin
                        if (wrong_pixels < 10)
                        begin
                            $display("pixel %0d (fmt %0d): expected we=%b %h %h %h %h",
                                     pixels_compared, fmt_shadow,
                                     want.write_enable, want.out_byte0, want.out_byte1,
                                     want.out_byte2, want.out_byte3);
                            $display("pixel %0d (fmt %0d): got      we=%b %h %h %h %h",
                                     pixels_compared, fmt_shadow,
                                     got.write_enable, got.out_byte0, got.out_byte1,
                                     got.out_byte2, got.out_byte3);
                        end
                        wrong_pixels <= wrong_pixels + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                blended_q.push_back(blend_pixel(in_data, fmt_shadow));
            pixels_waiting <= blended_q.size();
        end
    end

endmodule

// ===== bench/tb_alpha_blend_pixel_format_top.sv =====
module tb_alpha_blend_pixel_format_top;
    import abpf_pkg::*;

    localparam logic [2:0] FMT_UNDEF6 = 3'd6;
    localparam logic [2:0] FMT_UNDEF7 = 3'd7;
    // index 0 is the last entry
    localparam logic [7:0][2:0] FORMAT_ORDER = {FMT_UNDEF7, FMT_UNDEF6, FMT_GREYA,
                                                FMT_RGBA32, FMT_BGRX32, FMT_RGBX32,
                                                FMT_BGR24, FMT_RGB24};
    localparam int PIXELS_PER_FORMAT = 73;
    localparam int QUIET_LIMIT       = 4000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;

    int wrong_pixels;
    int pixels_waiting;
    int pixels_compared;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pixels_sent   = 0;
    int quiet_cycles  = 0;

    alpha_blend_pixel_format_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    abpf_blend_check check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .wrong_pixels    (wrong_pixels),
        .pixels_waiting  (pixels_waiting),
        .pixels_compared (pixels_compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no item moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_pixel(input in_item_t px);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic drain_pixels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_waiting != 0)
            @(negedge clk);
    endtask

    task automatic write_format(input logic [2:0] fmt);
        drain_pixels();
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // biased toward the alpha corners and saturated destination bytes
    function automatic in_item_t random_pixel();
        in_item_t px;
        px = in_item_t'({$urandom(), $urandom()});
        case ($urandom_range(0, 9))
            0: px.src_alpha = 8'h00;
            1: px.src_alpha = 8'hFF;
            2: px.src_alpha = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
            3:
            begin
                px.dst_byte1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.dst_byte3 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            4:
            begin
                px.src_red   = 8'hFF;
                px.src_green = 8'hFF;
                px.src_blue  = 8'hFF;
                px.dst_byte0 = 8'hFF;
                px.dst_byte1 = 8'hFF;
                px.dst_byte2 = 8'hFF;
                px.dst_byte3 = 8'hFF;
            end
            default: ;
        endcase
        return px;
    endfunction

    initial
    begin
        int phase;
        int f;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = FMT_RGBA32;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                // reset format is RGBA32: corners of alpha and color
                send_pixel(in_item_t'({8'hFF, 8'hFF, 8'hFF, 8'h00,
                                       8'hFF, 8'hFF, 8'hFF, 8'hFF}));
                send_pixel(in_item_t'({8'h00, 8'h00, 8'h00, 8'h00,
                                       8'h00, 8'h00, 8'h00, 8'h00}));
                send_pixel(in_item_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                       8'h00, 8'h00, 8'h00, 8'h00}));
                send_pixel(in_item_t'({8'h00, 8'h00, 8'h00, 8'hFF,
                                       8'hFF, 8'hFF, 8'hFF, 8'hFF}));
                send_pixel(in_item_t'({8'hFF, 8'hFF, 8'hFF, 8'hFE,
                                       8'h00, 8'h00, 8'h00, 8'h00}));
                send_pixel(in_item_t'({8'h00, 8'h00, 8'h00, 8'h01,
                                       8'hFF, 8'hFF, 8'hFF, 8'hFF}));
                send_pixel(in_item_t'({8'hFF, 8'hFF, 8'hFF, 8'h80,
                                       8'hFF, 8'hFF, 8'hFF, 8'hFF}));
                send_pixel(in_item_t'({8'hFF, 8'h00, 8'h80, 8'h80,
                                       8'h40, 8'hC0, 8'h20, 8'h00}));
                send_pixel(in_item_t'({8'h12, 8'h34, 8'h56, 8'h7F,
                                       8'h9A, 8'hBC, 8'hDE, 8'hF0}));
                send_pixel(in_item_t'({8'h01, 8'hFE, 8'h7F, 8'hFE,
                                       8'hFE, 8'h01, 8'h80, 8'hFF}));
            end
            for (f = 0; f < 8; f++)
            begin
                write_format(FORMAT_ORDER[3'((phase == 1) ? 7 - f : f)]);
                repeat (PIXELS_PER_FORMAT)
                    send_pixel(random_pixel());
            end
        end

        drain_pixels();
        repeat (12) @(negedge clk);
        $display("covered %0d pixels: directed alpha and color corners, then random pixels",
                 pixels_sent);
        $display("under all eight format codes and three stall patterns; %0d results compared",
                 pixels_compared);
        if (wrong_pixels == 0 && pixels_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
